### rtl/fcbs_pkg.sv
package fcbs_pkg;

  // Number of plane registers on the configuration port.
  localparam int REG_COUNT = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Plane coefficients are Q2.14, the offset is Q16.0.
  localparam int COEF_W = 16;
  localparam int D_SHIFT = 14;

  // Test kinds.
  localparam logic OP_BOX = 1'b0;
  localparam logic OP_SPHERE = 1'b1;

  // Packed layout of one plane register, most significant field first.
  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } plane_t;

  // Reset value: zero normal and an offset of one, so nothing is culled.
  localparam plane_t PLANE_RESET = plane_t'(CFG_DATA_W'(1));

  // Stage load enables handed from the pipeline control to the datapath.
  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
  } pipe_ctrl_t;

endpackage

### rtl/fcbs_plane_regs.sv
module fcbs_plane_regs
  import fcbs_pkg::*;
#(
  parameter int PLANE_COUNT = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output plane_t                planes [PLANE_COUNT]
);

  plane_t plane_r [PLANE_COUNT];

  // Planes past the register list are never written and keep their reset value.
  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
    if (i < REG_COUNT) begin : g_writable
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          plane_r[i] <= PLANE_RESET;
        end else if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
          plane_r[i] <= plane_t'(cfg_data);
        end
      end
    end else begin : g_fixed
      always_ff @(posedge clk) begin
        plane_r[i] <= PLANE_RESET;
      end
    end
    assign planes[i] = plane_r[i];
  end

endmodule

### rtl/fcbs_bound_sel.sv
module fcbs_bound_sel
  import fcbs_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          opcode,
  input  logic signed [COORD_WIDTH-1:0] box_min [3],
  input  logic signed [COORD_WIDTH-1:0] box_max [3],
  input  logic signed [COORD_WIDTH-1:0] center [3],
  input  logic        [COORD_WIDTH-2:0] radius,
  output logic signed [COORD_WIDTH-1:0] big_r [3],
  output logic signed [COORD_WIDTH-1:0] sml_r [3],
  output logic        [COORD_WIDTH-2:0] rad_r
);

  logic signed [COORD_WIDTH-1:0] big_nxt [3];
  logic signed [COORD_WIDTH-1:0] sml_nxt [3];
  logic        [COORD_WIDTH-2:0] rad_nxt;

  // For a box, the largest plane value comes from the larger coordinate on a
  // positive coefficient and the smaller one on a negative coefficient, axis by
  // axis. A sphere uses its centre on both sides and adds the radius margin.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (opcode == OP_SPHERE) begin
        big_nxt[k] = center[k];
        sml_nxt[k] = center[k];
      end else if (box_max[k] < box_min[k]) begin
        big_nxt[k] = box_min[k];
        sml_nxt[k] = box_max[k];
      end else begin
        big_nxt[k] = box_max[k];
        sml_nxt[k] = box_min[k];
      end
    end
    rad_nxt = (opcode == OP_SPHERE) ? radius : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_r <= big_nxt;
      sml_r <= sml_nxt;
      rad_r <= rad_nxt;
    end
  end

endmodule

### rtl/fcbs_plane_eval.sv
module fcbs_plane_eval
  import fcbs_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  pipe_ctrl_t                    ctrl,
  input  plane_t                        plane,
  input  logic signed [COORD_WIDTH-1:0] big [3],
  input  logic signed [COORD_WIDTH-1:0] sml [3],
  input  logic        [COORD_WIDTH-2:0] rad,
  output logic                          cull_r
);

  localparam int PROD_W = COORD_WIDTH + COEF_W;
  localparam int TERM_W = (PROD_W > COEF_W + D_SHIFT) ? PROD_W : COEF_W + D_SHIFT;
  localparam int SUM_W = TERM_W + 3;

  logic signed [COEF_W-1:0]      coef [3];
  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [PROD_W-1:0]      prod_nxt [3];
  logic signed [PROD_W-1:0]      prod_r [3];
  logic signed [SUM_W-1:0]       bias_nxt;
  logic signed [SUM_W-1:0]       bias_r;
  logic signed [SUM_W-1:0]       sum;
  logic                          cull_nxt;

  // Multiply stage: pick the point by coefficient sign, one product per axis.
  always_comb begin
    coef[0] = plane.a;
    coef[1] = plane.b;
    coef[2] = plane.c;
    for (int k = 0; k < 3; k++) begin
      pt[k] = coef[k][COEF_W-1] ? sml[k] : big[k];
      prod_nxt[k] = coef[k] * pt[k];
    end
    bias_nxt = (SUM_W'($signed(plane.d)) <<< D_SHIFT)
             + (SUM_W'({1'b0, rad}) << D_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_b) begin
      prod_r <= prod_nxt;
      bias_r <= bias_nxt;
    end
  end

  // Sum stage: the plane culls when the best value is not above zero.
  always_comb begin
    sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + bias_r;
    cull_nxt = sum[SUM_W-1] || (sum == '0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_c) begin
      cull_r <= cull_nxt;
    end
  end

endmodule

### rtl/frustum_cull_box_sphere_unit.sv
// Frustum culling unit: tests an axis-aligned box (opcode 0) or a sphere
// (opcode 1) against PLANE_COUNT planes and returns one visible bit per
// word. It takes one word every clock cycle unless the output side stalls.
// The four register stages are bound selection, one multiplier per plane and
// axis, the per-plane sum and sign test, and the output register that ORs
// the plane verdicts. After reset every plane passes everything. Plane
// registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no word is in flight, which the block does not
// enforce. Indexes beyond the six registers are ignored.
module frustum_cull_box_sphere_unit
  import fcbs_pkg::*;
#(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_z,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic        [COORD_WIDTH-2:0] in_sphere_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_visible
);

  plane_t                        planes [PLANE_COUNT];
  pipe_ctrl_t                    ctrl;
  logic signed [COORD_WIDTH-1:0] box_min [3];
  logic signed [COORD_WIDTH-1:0] box_max [3];
  logic signed [COORD_WIDTH-1:0] center [3];
  logic signed [COORD_WIDTH-1:0] big [3];
  logic signed [COORD_WIDTH-1:0] sml [3];
  logic        [COORD_WIDTH-2:0] rad;
  logic [PLANE_COUNT-1:0]        cull;
  logic                          va_r;
  logic                          vb_r;
  logic                          vc_r;
  logic                          out_valid_r;
  logic                          visible_r;
  logic                          rdy_b;
  logic                          rdy_c;
  logic                          rdy_o;

  assign box_min[0] = in_box_min_x;
  assign box_min[1] = in_box_min_y;
  assign box_min[2] = in_box_min_z;
  assign box_max[0] = in_box_max_x;
  assign box_max[1] = in_box_max_y;
  assign box_max[2] = in_box_max_z;
  assign center[0]  = in_center_x;
  assign center[1]  = in_center_y;
  assign center[2]  = in_center_z;

  // Each stage may load when it is empty or its contents move on.
  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy_c    = !vc_r || rdy_o;
  assign rdy_b    = !vb_r || rdy_c;
  assign in_ready = !va_r || rdy_b;

  assign ctrl.en_a = in_valid && in_ready;
  assign ctrl.en_b = va_r && rdy_b;
  assign ctrl.en_c = vb_r && rdy_c;

  // Valid bits travel alongside the datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
      if (rdy_o) begin
        out_valid_r <= vc_r;
      end
    end
  end

  // Output register: visible when no plane culls.
  always_ff @(posedge clk) begin
    if (vc_r && rdy_o) begin
      visible_r <= ~|cull;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;

  fcbs_plane_regs #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  fcbs_bound_sel #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sel (
    .clk     (clk),
    .en      (ctrl.en_a),
    .opcode  (in_opcode),
    .box_min (box_min),
    .box_max (box_max),
    .center  (center),
    .radius  (in_sphere_radius),
    .big_r   (big),
    .sml_r   (sml),
    .rad_r   (rad)
  );

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_eval
    fcbs_plane_eval #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_eval (
      .clk    (clk),
      .ctrl   (ctrl),
      .plane  (planes[i]),
      .big    (big),
      .sml    (sml),
      .rad    (rad),
      .cull_r (cull[i])
    );
  end

endmodule

### rtl/fcbs_check.sv
module fcbs_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_visible
);

  // No word is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A free-running output side never holds back the input side.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // Checks that out_valid rises once an accepted word has passed the stage registers while out_ready was high.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> ##1 out_valid)
    else $error("accepted word did not arrive at the output");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_visible)))
    else $error("stalled result word changed");

endmodule

bind frustum_cull_box_sphere_unit fcbs_check u_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_visible (out_visible)
);
